@@ hw/rtl/gcds_pkg.sv @@
// Package with the microcode, codes and month table of the calendar date stepper.
`timescale 1ns / 1ps
`default_nettype none

package gcds_pkg;

    localparam int unsigned C_MAX_STEP = 1023;

    localparam int unsigned C_DAY_W   = 5;
    localparam int unsigned C_MONTH_W = 4;
    localparam int unsigned C_YEAR_W  = 16;
    localparam int unsigned C_CNT_W   = 10;
    localparam int unsigned C_OP_W    = 2;
    localparam int unsigned C_MOD_W   = 9;
    localparam int unsigned C_PC_W    = 4;

    localparam logic [C_OP_W-1:0] C_OP_LOAD = 2'd0;
    localparam logic [C_OP_W-1:0] C_OP_FWD  = 2'd1;
    localparam logic [C_OP_W-1:0] C_OP_BWD  = 2'd2;
    localparam logic [C_OP_W-1:0] C_OP_NONE = 2'd3;

    // Year divided by 400 is (year * C_RECIP_400) >> C_RECIP_SHIFT for every 16-bit year.
    localparam int unsigned C_RECIP_W     = 17;
    localparam int unsigned C_PROD_W      = C_YEAR_W + C_RECIP_W;
    localparam int unsigned C_RECIP_SHIFT = 25;
    localparam int unsigned C_QUOT_W      = C_PROD_W - C_RECIP_SHIFT;
    localparam logic [C_RECIP_W-1:0] C_RECIP_400 = 17'd83887;
    localparam logic [C_MOD_W-1:0]   C_QUAD_CENT = 9'd400;
    localparam logic [C_MOD_W-1:0]   C_MOD_LAST  = 9'd399;
    localparam logic [C_MOD_W-1:0]   C_MOD_TOP   = 9'd335;
    localparam logic [C_YEAR_W-1:0]  C_YEAR_TOP  = 16'hFFFF;

    localparam logic [C_MONTH_W-1:0] C_JAN = 4'd1;
    localparam logic [C_MONTH_W-1:0] C_DEC = 4'd12;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_MUL,
        ACT_REM,
        ACT_LOAD,
        ACT_DAY,
        ACT_EMIT
    } t_act;

    typedef enum logic [2:0] {
        CND_ALWAYS,
        CND_NOT_ACC,
        CND_OP_LOAD,
        CND_OP_NONE,
        CND_CNT_ZERO,
        CND_CNT_MORE,
        CND_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_act              act;
        t_cond             cond;
        logic [C_PC_W-1:0] target;
    } t_uword;

    localparam logic [C_PC_W-1:0] PC_WAIT = 4'd0;
    localparam logic [C_PC_W-1:0] PC_DAY  = 4'd4;
    localparam logic [C_PC_W-1:0] PC_EMIT = 4'd5;
    localparam logic [C_PC_W-1:0] PC_REM  = 4'd7;

    function automatic t_uword f_ucode(input logic [C_PC_W-1:0] pc);
        t_uword w;
        w = '{act: ACT_NONE, cond: CND_ALWAYS, target: PC_WAIT};
        case (pc)
            4'd0: w = '{act: ACT_NONE, cond: CND_NOT_ACC,  target: PC_WAIT};
            4'd1: w = '{act: ACT_MUL,  cond: CND_OP_LOAD,  target: PC_REM};
            4'd2: w = '{act: ACT_NONE, cond: CND_OP_NONE,  target: PC_EMIT};
            4'd3: w = '{act: ACT_NONE, cond: CND_CNT_ZERO, target: PC_EMIT};
            4'd4: w = '{act: ACT_DAY,  cond: CND_CNT_MORE, target: PC_DAY};
            4'd5: w = '{act: ACT_EMIT, cond: CND_OUT_FREE, target: PC_WAIT};
            4'd6: w = '{act: ACT_NONE, cond: CND_ALWAYS,   target: PC_EMIT};
            4'd7: w = '{act: ACT_REM,  cond: CND_ALWAYS,   target: 4'd8};
            4'd8: w = '{act: ACT_LOAD, cond: CND_ALWAYS,   target: PC_EMIT};
            default: w = '{act: ACT_NONE, cond: CND_ALWAYS, target: PC_WAIT};
        endcase
        return w;
    endfunction

    function automatic logic [C_DAY_W-1:0] f_month_len(input logic [C_MONTH_W-1:0] m,
                                                       input logic leap);
        logic [C_DAY_W-1:0] n;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:                                       n = leap ? 5'd29 : 5'd28;
            default:                                    n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic logic f_leap(input logic [C_MOD_W-1:0] ymod);
        logic l;
        l = ((ymod[1:0] == 2'd0) && !(ymod inside {9'd100, 9'd200, 9'd300}))
            || (ymod == 9'd0);
        return l;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gregorian_calendar_date_stepper_top.sv @@
// Top level of the calendar date stepper: microcoded sequencer and date datapath.
// A load word goes from acceptance through the multiply, remainder and load steps to emit,
// an unused opcode through the opcode checks to emit, and a step word of k days through the
// checks and the day-step unit, one day per cycle, to emit. One word is in work at a time; the
// next is accepted the cycle after the result enters the output register.
// Synchronous active-low reset sets 1 January of year 1 and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_calendar_date_stepper_top
    import gcds_pkg::*;
#(
    parameter int unsigned MAX_STEP = C_MAX_STEP
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [C_OP_W-1:0]    i_opcode,
    input  wire logic [C_DAY_W-1:0]   i_day_in,
    input  wire logic [C_MONTH_W-1:0] i_month_in,
    input  wire logic [C_YEAR_W-1:0]  i_year_in,
    input  wire logic [C_CNT_W-1:0]   i_step_count,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [C_DAY_W-1:0]        o_day_out,
    output logic [C_MONTH_W-1:0]      o_month_out,
    output logic [C_YEAR_W-1:0]       o_year_out,
    output logic                      o_load_error
);

    localparam int unsigned CMP_W = 17;

    logic [C_PC_W-1:0]    r_pc, n_pc;
    t_uword               uw;
    logic                 jump;
    logic                 in_acc;
    logic                 out_free;

    logic [C_OP_W-1:0]    r_op;
    logic [C_DAY_W-1:0]   r_day_in;
    logic [C_MONTH_W-1:0] r_month_in;
    logic [C_YEAR_W-1:0]  r_year_in;
    logic [C_CNT_W-1:0]   r_cnt, n_cnt_load;
    logic [C_PROD_W-1:0]  r_prod;
    logic [C_MOD_W-1:0]   r_lmod;
    logic                 r_err;

    logic [C_DAY_W-1:0]   r_day, n_day;
    logic [C_MONTH_W-1:0] r_month, n_month;
    logic [C_YEAR_W-1:0]  r_year, n_year;
    logic [C_MOD_W-1:0]   r_ymod, n_ymod;

    logic                 r_out_valid;
    logic [C_DAY_W-1:0]   r_day_out;
    logic [C_MONTH_W-1:0] r_month_out;
    logic [C_YEAR_W-1:0]  r_year_out;
    logic                 r_err_out;

    logic [C_QUOT_W-1:0]  quot;
    logic [CMP_W-1:0]     quot_x400;
    logic [C_YEAR_W-1:0]  rem_full;
    logic                 cur_leap;
    logic [C_DAY_W-1:0]   cur_len;
    logic [C_DAY_W-1:0]   load_len;
    logic                 load_ok;

    assign uw       = f_ucode(r_pc);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_pc != PC_WAIT);

    always_comb begin
        case (uw.cond)
            CND_ALWAYS:   jump = 1'b1;
            CND_NOT_ACC:  jump = !in_acc;
            CND_OP_LOAD:  jump = (r_op == C_OP_LOAD);
            CND_OP_NONE:  jump = (r_op == C_OP_NONE);
            CND_CNT_ZERO: jump = (r_cnt == '0);
            CND_CNT_MORE: jump = (r_cnt > C_CNT_W'(1));
            CND_OUT_FREE: jump = out_free;
            default:      jump = 1'b1;
        endcase
        n_pc = jump ? uw.target : r_pc + C_PC_W'(1);
    end

    always_comb begin
        if ({{(CMP_W-C_CNT_W){1'b0}}, i_step_count} > CMP_W'(MAX_STEP)) begin
            n_cnt_load = C_CNT_W'(MAX_STEP);
        end else begin
            n_cnt_load = i_step_count;
        end
    end

    assign quot      = r_prod[C_PROD_W-1:C_RECIP_SHIFT];
    assign quot_x400 = {{(CMP_W-C_QUOT_W){1'b0}}, quot} * {{(CMP_W-C_MOD_W){1'b0}}, C_QUAD_CENT};
    assign rem_full  = r_year_in - quot_x400[C_YEAR_W-1:0];
    assign cur_leap  = f_leap(r_ymod);
    assign cur_len   = f_month_len(r_month, cur_leap);
    assign load_len  = f_month_len(r_month_in, f_leap(r_lmod));
    assign load_ok   = (r_month_in inside {[C_JAN:C_DEC]}) && (r_day_in != '0)
                       && (r_day_in <= load_len);

    always_comb begin
        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        n_ymod  = r_ymod;
        if (uw.act == ACT_LOAD) begin
            if (load_ok) begin
                n_day   = r_day_in;
                n_month = r_month_in;
                n_year  = r_year_in;
                n_ymod  = r_lmod;
            end
        end else if (uw.act == ACT_DAY) begin
            if (r_op == C_OP_FWD) begin
                if (r_day >= cur_len) begin
                    n_day = C_DAY_W'(1);
                    if (r_month >= C_DEC) begin
                        n_month = C_JAN;
                        n_year  = r_year + C_YEAR_W'(1);
                        if (r_year == C_YEAR_TOP || r_ymod == C_MOD_LAST) begin
                            n_ymod = '0;
                        end else begin
                            n_ymod = r_ymod + C_MOD_W'(1);
                        end
                    end else begin
                        n_month = r_month + C_MONTH_W'(1);
                    end
                end else begin
                    n_day = r_day + C_DAY_W'(1);
                end
            end else begin
                if (r_day <= C_DAY_W'(1)) begin
                    if (r_month <= C_JAN) begin
                        n_month = C_DEC;
                        n_year  = r_year - C_YEAR_W'(1);
                        if (r_year == '0) begin
                            n_ymod = C_MOD_TOP;
                        end else if (r_ymod == '0) begin
                            n_ymod = C_MOD_LAST;
                        end else begin
                            n_ymod = r_ymod - C_MOD_W'(1);
                        end
                    end else begin
                        n_month = r_month - C_MONTH_W'(1);
                    end
                    n_day = f_month_len(n_month, cur_leap);
                end else begin
                    n_day = r_day - C_DAY_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_WAIT;
            r_out_valid <= 1'b0;
            r_day       <= C_DAY_W'(1);
            r_month     <= C_JAN;
            r_year      <= C_YEAR_W'(1);
            r_ymod      <= C_MOD_W'(1);
        end else begin
            r_pc    <= n_pc;
            r_day   <= n_day;
            r_month <= n_month;
            r_year  <= n_year;
            r_ymod  <= n_ymod;
            if (uw.act == ACT_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op       <= i_opcode;
            r_day_in   <= i_day_in;
            r_month_in <= i_month_in;
            r_year_in  <= i_year_in;
            r_cnt      <= n_cnt_load;
            r_err      <= 1'b0;
        end
        case (uw.act)
            ACT_MUL:  r_prod <= {{C_RECIP_W{1'b0}}, r_year_in}
                                * {{C_YEAR_W{1'b0}}, C_RECIP_400};
            ACT_REM:  r_lmod <= rem_full[C_MOD_W-1:0];
            ACT_LOAD: r_err  <= !load_ok;
            ACT_DAY:  r_cnt  <= r_cnt - C_CNT_W'(1);
            ACT_EMIT: begin
                if (out_free) begin
                    r_day_out   <= r_day;
                    r_month_out <= r_month;
                    r_year_out  <= r_year;
                    r_err_out   <= r_err;
                end
            end
            default: ;
        endcase
    end

    assign o_valid      = r_out_valid;
    assign o_day_out    = r_day_out;
    assign o_month_out  = r_month_out;
    assign o_year_out   = r_year_out;
    assign o_load_error = r_err_out;

endmodule

`default_nettype wire

@@ tb/tb_gregorian_calendar_date_stepper_top.sv @@
// Self-checking testbench for the calendar date stepper: directed and random words vs. a date predictor.
`timescale 1ns / 1ps

module tb_gregorian_calendar_date_stepper_top;
    import gcds_pkg::*;

    localparam int unsigned RANDOM_WORDS = 580;
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam int unsigned DRAIN_CYCLES = 1100;

    typedef struct {
        logic [C_OP_W-1:0]    op;
        logic [C_DAY_W-1:0]   day;
        logic [C_MONTH_W-1:0] month;
        logic [C_YEAR_W-1:0]  year;
        logic [C_CNT_W-1:0]   count;
        logic                 drain;
    } cal_word_t;

    typedef struct {
        logic [C_DAY_W-1:0]   day;
        logic [C_MONTH_W-1:0] month;
        logic [C_YEAR_W-1:0]  year;
        logic                 err;
    } date_result_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [C_OP_W-1:0]    i_opcode = C_OP_NONE;
    logic [C_DAY_W-1:0]   i_day_in = '0;
    logic [C_MONTH_W-1:0] i_month_in = '0;
    logic [C_YEAR_W-1:0]  i_year_in = '0;
    logic [C_CNT_W-1:0]   i_step_count = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [C_DAY_W-1:0]   o_day_out;
    logic [C_MONTH_W-1:0] o_month_out;
    logic [C_YEAR_W-1:0]  o_year_out;
    logic                 o_load_error;

    cal_word_t    word_q[$];
    date_result_t date_expect_q[$];
    cal_word_t    cur_word;

    logic [C_DAY_W-1:0]   cal_day = 5'd1;
    logic [C_MONTH_W-1:0] cal_month = C_JAN;
    logic [C_YEAR_W-1:0]  cal_year = 16'd1;

    int unsigned n_accepted = 0;
    int unsigned n_checked = 0;
    int unsigned n_errors = 0;
    int unsigned n_cycles = 0;
    int unsigned gap_left = 0;
    int unsigned burst_left = 1;
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;
    int unsigned stall_run = 0;
    logic        fire;

    gregorian_calendar_date_stepper_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_day_in     (i_day_in),
        .i_month_in   (i_month_in),
        .i_year_in    (i_year_in),
        .i_step_count (i_step_count),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_day_out    (o_day_out),
        .o_month_out  (o_month_out),
        .o_year_out   (o_year_out),
        .o_load_error (o_load_error)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit leap_year(input logic [C_YEAR_W-1:0] y);
        int unsigned v;
        v = y;
        return ((v % 4 == 0) && (v % 100 != 0)) || (v % 400 == 0);
    endfunction

    function automatic logic [C_DAY_W-1:0] month_days(input logic [C_MONTH_W-1:0] m,
                                                      input logic [C_YEAR_W-1:0] y);
        logic [C_DAY_W-1:0] n;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:                                       n = leap_year(y) ? 5'd29 : 5'd28;
            default:                                    n = 5'd0;
        endcase
        return n;
    endfunction

    task automatic next_day();
        if (cal_day >= month_days(cal_month, cal_year)) begin
            cal_day = 5'd1;
            if (cal_month >= C_DEC) begin
                cal_month = C_JAN;
                cal_year = cal_year + 16'd1;
            end else begin
                cal_month = cal_month + 4'd1;
            end
        end else begin
            cal_day = cal_day + 5'd1;
        end
    endtask

    task automatic prev_day();
        if (cal_day <= 5'd1) begin
            if (cal_month <= C_JAN) begin
                cal_month = C_DEC;
                cal_year = cal_year - 16'd1;
            end else begin
                cal_month = cal_month - 4'd1;
            end
            cal_day = month_days(cal_month, cal_year);
        end else begin
            cal_day = cal_day - 5'd1;
        end
    endtask

    task automatic apply_word(input cal_word_t w);
        date_result_t r;
        int unsigned  i;
        r.err = 1'b0;
        case (w.op)
            C_OP_LOAD: begin
                if (w.month >= C_JAN && w.month <= C_DEC && w.day != 5'd0
                        && w.day <= month_days(w.month, w.year)) begin
                    cal_day = w.day;
                    cal_month = w.month;
                    cal_year = w.year;
                end else begin
                    r.err = 1'b1;
                end
            end
            C_OP_FWD: begin
                for (i = 0; i < w.count; i++) next_day();
            end
            C_OP_BWD: begin
                for (i = 0; i < w.count; i++) prev_day();
            end
            default: begin
            end
        endcase
        r.day = cal_day;
        r.month = cal_month;
        r.year = cal_year;
        date_expect_q.push_back(r);
    endtask

    task automatic add_word(input logic [C_OP_W-1:0] op, input int unsigned d,
                            input int unsigned m, input int unsigned y,
                            input int unsigned cnt, input bit drain);
        cal_word_t w;
        w.op = op;
        w.day = d[C_DAY_W-1:0];
        w.month = m[C_MONTH_W-1:0];
        w.year = y[C_YEAR_W-1:0];
        w.count = cnt[C_CNT_W-1:0];
        w.drain = drain;
        word_q.push_back(w);
    endtask

    function automatic int unsigned pick_year();
        int unsigned y;
        y = $urandom_range(0, 65535);
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 7))
                0: y = 0;
                1: y = 1;
                2: y = 4;
                3: y = 1900;
                4: y = 2000;
                5: y = 2100;
                6: y = 65535;
                default: y = 65532;
            endcase
        end
        return y;
    endfunction

    function automatic int unsigned pick_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return $urandom_range(0, 3);
        if (r < 70) return $urandom_range(0, 40);
        if (r < 94) return $urandom_range(0, 400);
        return $urandom_range(0, 1023);
    endfunction

    // Sender: bursts of words separated by random gaps; a marked word waits for a full drain.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            fire = i_valid && !o_stall;
            if (fire) begin
                apply_word(cur_word);
                n_accepted <= n_accepted + 1;
            end
            if (!i_valid || fire) begin
                if (gap_left != 0) begin
                    gap_left = gap_left - 1;
                    i_valid <= 1'b0;
                end else if (word_q.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (word_q[0].drain && (fire || n_accepted != n_checked)) begin
                    i_valid <= 1'b0;
                end else begin
                    cur_word = word_q.pop_front();
                    i_valid <= 1'b1;
                    i_opcode <= cur_word.op;
                    i_day_in <= cur_word.day;
                    i_month_in <= cur_word.month;
                    i_year_in <= cur_word.year;
                    i_step_count <= cur_word.count;
                    burst_left = burst_left - 1;
                    if (burst_left == 0) begin
                        if ($urandom_range(0, 3) == 0) begin
                            gap_left = 0;
                            burst_left = 40;
                        end else begin
                            gap_left = $urandom_range(0, 20);
                            burst_left = $urandom_range(1, 8);
                        end
                    end
                end
            end
        end
    end

    // Receiver: checks each result word and stalls in quiet, random and long-run modes.
    always @(posedge i_clk) begin
        date_result_t want;
        logic         stall_next;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (date_expect_q.size() == 0) begin
                    $error("unexpected result word: day %0d month %0d year %0d error %0d",
                           o_day_out, o_month_out, o_year_out, o_load_error);
                    n_errors++;
                end else begin
                    want = date_expect_q.pop_front();
                    n_checked <= n_checked + 1;
                    if (o_day_out !== want.day) begin
                        $error("day_out expected %0d got %0d", want.day, o_day_out);
                        n_errors++;
                    end
                    if (o_month_out !== want.month) begin
                        $error("month_out expected %0d got %0d", want.month, o_month_out);
                        n_errors++;
                    end
                    if (o_year_out !== want.year) begin
                        $error("year_out expected %0d got %0d", want.year, o_year_out);
                        n_errors++;
                    end
                    if (o_load_error !== want.err) begin
                        $error("load_error expected %0d got %0d", want.err, o_load_error);
                        n_errors++;
                    end
                end
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 400);
            end
            mode_left = mode_left - 1;
            stall_next = 1'b0;
            if (stall_mode == 1) begin
                stall_next = ($urandom_range(0, 2) == 0);
            end else if (stall_mode == 2) begin
                if (stall_run != 0) begin
                    stall_run = stall_run - 1;
                    stall_next = 1'b1;
                end else if ($urandom_range(0, 9) == 0) begin
                    stall_run = $urandom_range(1, 15);
                    stall_next = 1'b1;
                end
            end
            i_stall <= stall_next;
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("tb_gregorian_calendar_date_stepper_top failed");
            $finish;
        end
    end

    initial begin
        int unsigned n;
        int unsigned r;
        int unsigned d;
        int unsigned m;
        int unsigned y;
        bit          drain;

        add_word(C_OP_NONE, $urandom, $urandom, $urandom, $urandom, 1'b0);
        add_word(C_OP_FWD, $urandom, $urandom, $urandom, 0, 1'b0);
        add_word(C_OP_LOAD, 31, 12, 65535, $urandom, 1'b0);
        add_word(C_OP_FWD, $urandom, $urandom, $urandom, 1, 1'b0);
        add_word(C_OP_BWD, $urandom, $urandom, $urandom, 1, 1'b0);
        add_word(C_OP_LOAD, 1, 1, 0, $urandom, 1'b0);
        add_word(C_OP_BWD, $urandom, $urandom, $urandom, 1, 1'b0);
        add_word(C_OP_LOAD, 29, 2, 1900, 0, 1'b0);
        add_word(C_OP_LOAD, 29, 2, 2000, 1023, 1'b0);
        add_word(C_OP_LOAD, 29, 2, 2024, 0, 1'b0);
        add_word(C_OP_LOAD, 30, 2, 2024, 0, 1'b0);
        add_word(C_OP_LOAD, 31, 4, 2023, 0, 1'b0);
        add_word(C_OP_LOAD, 0, 5, 2023, 0, 1'b0);
        add_word(C_OP_LOAD, 15, 0, 2023, 0, 1'b0);
        add_word(C_OP_LOAD, 15, 13, 2023, 0, 1'b0);
        add_word(C_OP_LOAD, 31, 15, 65535, 1023, 1'b0);
        add_word(C_OP_FWD, 31, 15, 65535, 1023, 1'b1);
        add_word(C_OP_BWD, 0, 0, 0, 1023, 1'b0);
        add_word(C_OP_LOAD, 28, 2, 2100, 0, 1'b0);
        add_word(C_OP_FWD, 0, 0, 0, 1, 1'b0);
        add_word(C_OP_LOAD, 1, 3, 0, 0, 1'b0);
        add_word(C_OP_BWD, 0, 0, 0, 1, 1'b0);
        add_word(C_OP_NONE, 31, 15, 65535, 1023, 1'b0);
        add_word(C_OP_LOAD, 31, 1, 0, 0, 1'b0);

        for (n = 0; n < RANDOM_WORDS; n++) begin
            r = $urandom_range(0, 99);
            drain = ($urandom_range(0, 99) == 0);
            if (r < 16) begin
                m = $urandom_range(1, 12);
                y = pick_year();
                d = month_days(m, y);
                if ($urandom_range(0, 2) != 0) d = $urandom_range(1, d);
                add_word(C_OP_LOAD, d, m, y, $urandom, drain);
            end else if (r < 23) begin
                add_word(C_OP_LOAD, $urandom, $urandom, $urandom, $urandom, drain);
            end else if (r < 26) begin
                add_word(C_OP_NONE, $urandom, $urandom, $urandom, $urandom, drain);
            end else if (r < 63) begin
                add_word(C_OP_FWD, $urandom, $urandom, $urandom, pick_count(), drain);
            end else begin
                add_word(C_OP_BWD, $urandom, $urandom, $urandom, pick_count(), drain);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (word_q.size() != 0 || i_valid || n_accepted != n_checked) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("tb_gregorian_calendar_date_stepper_top passed");
        end else begin
            $display("tb_gregorian_calendar_date_stepper_top failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/gcds_pkg.sv
hw/rtl/gregorian_calendar_date_stepper_top.sv
tb/tb_gregorian_calendar_date_stepper_top.sv
